// ===== hdl/ter_pkg.sv =====
// Shared types and constants for the triangle edge rasteriser.
// Request and result payloads, the setup bundle passed from ter_setup to ter_walker.
// No dependencies.
`default_nettype none

package ter_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int EDGE_BITS  = 2 * COORD_BITS + 3;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;

  typedef struct packed {
    logic   mode;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
  } in_req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   covered;
    logic   last_pixel;
  } out_res_t;

  typedef struct packed {
    coord_t           xmin;
    coord_t           xmax;
    coord_t           ymin;
    coord_t           ymax;
    diff_t  [2:0]     dy;
    edge_t  [2:0]     rstep;
    edge_t  [2:0]     e0;
  } setup_t;

endpackage

`default_nettype wire

// ===== hdl/ter_setup.sv =====
// Triangle setup: bounding box, edge deltas, edge values at the top-left corner.
// Purely combinational; uses ter_pkg.
`default_nettype none

module ter_setup
  import ter_pkg::*;
(
  input  in_req_t req,
  output setup_t  setup
);

  coord_t vx [3];
  coord_t vy [3];
  coord_t xmin, xmax, ymin, ymax;
  diff_t  span;

  assign vx[0] = req.ax;
  assign vy[0] = req.ay;
  assign vx[1] = req.bx;
  assign vy[1] = req.by_coord;
  assign vx[2] = req.cx;
  assign vy[2] = req.cy;

  always_comb begin
    xmin = vx[0];
    xmax = vx[0];
    ymin = vy[0];
    ymax = vy[0];
    if (vx[1] < xmin) xmin = vx[1];
    if (vx[2] < xmin) xmin = vx[2];
    if (vx[1] > xmax) xmax = vx[1];
    if (vx[2] > xmax) xmax = vx[2];
    if (vy[1] < ymin) ymin = vy[1];
    if (vy[2] < ymin) ymin = vy[2];
    if (vy[1] > ymax) ymax = vy[1];
    if (vy[2] > ymax) ymax = vy[2];
  end

  assign span = diff_t'(xmax) - diff_t'(xmin);

  assign setup.xmin = xmin;
  assign setup.xmax = xmax;
  assign setup.ymin = ymin;
  assign setup.ymax = ymax;

  // One lane per edge: edge g runs from vertex g to the next vertex.
  for (genvar g = 0; g < 3; g++) begin : g_edge
    localparam int N = (g + 1) % 3;
    diff_t dx;
    diff_t dy;
    diff_t ox;
    diff_t oy;
    logic signed [2*DIFF_BITS-1:0] p_a;
    logic signed [2*DIFF_BITS-1:0] p_b;
    logic signed [2*DIFF_BITS-1:0] p_r;

    assign dx  = diff_t'(vx[N]) - diff_t'(vx[g]);
    assign dy  = diff_t'(vy[N]) - diff_t'(vy[g]);
    assign ox  = diff_t'(xmin) - diff_t'(vx[g]);
    assign oy  = diff_t'(ymax) - diff_t'(vy[g]);
    assign p_a = ox * dy;
    assign p_b = oy * dx;
    assign p_r = span * dy;

    assign setup.dy[g]    = dy;
    assign setup.e0[g]    = edge_t'(p_a) - edge_t'(p_b);
    assign setup.rstep[g] = edge_t'(dx) - edge_t'(p_r);
  end

endmodule

`default_nettype wire

// ===== hdl/ter_walker.sv =====
// Traversal state: cursor, bounding box and incremental edge values.
// Consumes the ter_setup bundle on load; uses ter_pkg.
`default_nettype none

module ter_walker
  import ter_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  logic     mode,
  input  setup_t   setup,
  output logic     res_valid,
  output out_res_t res
);

  logic   active_r, active_nxt;
  coord_t xmin_r, xmax_r, ymin_r;
  coord_t xmin_nxt, xmax_nxt, ymin_nxt;
  coord_t cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  edge_t  edge_r  [3];
  edge_t  edge_nxt[3];
  edge_t  rstep_r [3];
  edge_t  rstep_nxt[3];
  diff_t  dy_r    [3];
  diff_t  dy_nxt  [3];

  logic is_load, is_step, row_end, last;

  assign is_load = step_en && (mode == MODE_LOAD);
  assign is_step = step_en && (mode == MODE_ADVANCE) && active_r;
  assign row_end = (cur_x_r >= xmax_r);
  assign last    = row_end && (cur_y_r <= ymin_r);

  assign res_valid      = is_step;
  assign res.pixel_x    = cur_x_r;
  assign res.pixel_y    = cur_y_r;
  assign res.covered    = (edge_r[0] > 0) && (edge_r[1] > 0) && (edge_r[2] > 0);
  assign res.last_pixel = last;

  // Per-edge update: load, step right by dy, or wrap to the next row.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    always_comb begin
      edge_nxt[g]  = edge_r[g];
      rstep_nxt[g] = rstep_r[g];
      dy_nxt[g]    = dy_r[g];
      if (is_load) begin
        edge_nxt[g]  = $signed(setup.e0[g]);
        rstep_nxt[g] = $signed(setup.rstep[g]);
        dy_nxt[g]    = $signed(setup.dy[g]);
      end else if (is_step && !last) begin
        if (row_end) begin
          edge_nxt[g] = edge_r[g] + rstep_r[g];
        end else begin
          edge_nxt[g] = edge_r[g] + edge_t'(dy_r[g]);
        end
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    xmin_nxt   = xmin_r;
    xmax_nxt   = xmax_r;
    ymin_nxt   = ymin_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    if (is_load) begin
      active_nxt = 1'b1;
      xmin_nxt   = setup.xmin;
      xmax_nxt   = setup.xmax;
      ymin_nxt   = setup.ymin;
      cur_x_nxt  = setup.xmin;
      cur_y_nxt  = setup.ymax;
    end else if (is_step) begin
      if (last) begin
        active_nxt = 1'b0;
      end else if (row_end) begin
        cur_x_nxt = xmin_r;
        cur_y_nxt = cur_y_r - coord_t'(1);
      end else begin
        cur_x_nxt = cur_x_r + coord_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xmin_r  <= xmin_nxt;
    xmax_r  <= xmax_nxt;
    ymin_r  <= ymin_nxt;
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    edge_r  <= edge_nxt;
    rstep_r <= rstep_nxt;
    dy_r    <= dy_nxt;
  end

  a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
    is_load |=> active_r)
    else $error("load did not start a traversal");

  a_cursor_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cur_x_r >= xmin_r) && (cur_x_r <= xmax_r) && (cur_y_r >= ymin_r))
    else $error("cursor left the bounding box");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last_pixel) |=> !active_r)
    else $error("traversal continued after the final position");

endmodule

`default_nettype wire

// ===== hdl/triangle_edge_rasterizer.sv =====
// Top level of the edge-function triangle rasteriser; depends on ter_pkg, ter_setup, ter_walker.
// A request is held in the input register; its result is then captured in the result register that drives out_res.
// Throughput: one request per cycle; each register takes a new request whenever the
// stage after it moves on, so the input stalls only behind a result that is held.
// A load request gives no result; an advance request gives one while a triangle is open.
// Reset (rst_n low, synchronous) empties both registers and closes any open triangle.
`default_nettype none

module triangle_edge_rasterizer
  import ter_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_res
);

  // Input register: hold the request until the result side can take its outcome.
  logic     s1_valid_r, s1_valid_nxt;
  in_req_t  s1_req_r;
  logic     s1_fire;

  // Result register.
  logic     out_valid_r, out_valid_nxt;
  out_res_t out_res_r;

  setup_t   setup;
  logic     res_valid;
  out_res_t res;

  // Advance the input register whenever the result slot is free or being drained,
  // whether or not this request makes a result.
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r <= in_req;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  ter_setup u_setup (
    .req   (s1_req_r),
    .setup (setup)
  );

  ter_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_fire),
    .mode      (s1_req_r.mode),
    .setup     (setup),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Input side stalls only when a request is waiting behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a held result");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_valid_r || out_ready)
    else $error("result register overwritten while held");

  // A result that is not taken stays put, payload unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_res_r))
    else $error("held result changed before it was taken");

endmodule

`default_nettype wire
